[rtl/core/pcd_pkg.sv]
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants of the parity checked prefix code decoder:
// item and result words, opcodes, controller command and status groups.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int MAX_CODE_LEN_DEF = 10;
	localparam int DATA_BITS        = 8;
	localparam int NIBBLE_BITS      = 4;
	localparam int SYM_W            = 8;
	localparam int MLEN_W           = 16;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  nibble;
		logic [9:0]  code_bits;
		logic [3:0]  code_length;
		logic [7:0]  entry_symbol;
	} item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       message_full;
	} result_t;

	typedef logic [MLEN_W-1:0] cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic take_nib;
		logic shift_bit;
		logic next_bit;
		logic drop_group;
		logic start_match;
		logic match_step;
		logic next_k;
		logic take_hit;
		logic flush;
		logic clr_start;
		logic clr_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic grp_full;
		logic parity_odd;
		logic bit_last;
		logic k_last;
		logic lookup_ok;
		logic hit;
		logic hold_v;
		logic can_push;
		logic clr_done;
	} sts_t;

endpackage

[rtl/core/pcd_stream_if.sv]
// ----------------------------------------------------------------------------
// pcd_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface pcd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/parity_checked_prefix_code_decoder.sv]
// ----------------------------------------------------------------------------
// parity_checked_prefix_code_decoder
// Odd-parity byte filter feeding a table driven prefix code decoder.
// ----------------------------------------------------------------------------
// Channels: item (sink) takes one word per op: a table load, a hex nibble or
// a new-message clear. result (source) gives decoded symbols, last marking
// the final symbol caused by one nibble. cfg (sink) writes message_length,
// always ready; write it only while the block is idle.
// Sequence: a load or an unused op leaves the block idle and ready for the
// next word. A nibble is accepted in idle, each of its bits is then handled
// in the bit state, and the flush state ends it. The bit that completes a
// kept group starts a lookup of each data bit in turn (lookup issue, then
// registered read of the table memory). A new-message op and reset each
// start a clearing sweep of all 2 << MAX_CODE_LEN code table entries
// (2048 by default), during which item.ready is low.
// Results leave through an output register with a one-word hold behind it;
// once both are taken and the receiver stalls, decoding halts at the next
// symbol found and the flush cycle waits.
// ----------------------------------------------------------------------------
module parity_checked_prefix_code_decoder #(
	parameter int MAX_CODE_LEN = pcd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pcd_stream_if.sink    item,
	pcd_stream_if.source  result,
	pcd_stream_if.sink    cfg
);

	pcd_pkg::cmd_t cmd;
	pcd_pkg::sts_t sts;
	logic          in_ready;
	pcd_pkg::item_t item_data;

	assign item_data  = item.data;
	assign item.ready = in_ready;

	pcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item_data.op),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pcd_datapath #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item_data),
		.result    (result),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[rtl/core/pcd_ctrl.sv]
// ----------------------------------------------------------------------------
// pcd_ctrl
// Sequencer of the decoder: table clearing sweep, item dispatch, per-bit
// grouping, per-bit table lookups and result flushing.
// ----------------------------------------------------------------------------
module pcd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_op,
	output logic            in_ready,
	output pcd_pkg::cmd_t   cmd,
	input  pcd_pkg::sts_t   sts
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_BIT   = 6'b000100,
		ST_MATCH = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_op)
						pcd_pkg::OP_LOAD: begin
							cmd.load = 1'b1;
						end
						pcd_pkg::OP_DATA: begin
							cmd.take_nib = 1'b1;
							state_d      = ST_BIT;
						end
						pcd_pkg::OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = ST_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			ST_BIT: begin
				priority if (sts.full) begin
					state_d = ST_FLUSH;
				end else if (!sts.grp_full) begin
					cmd.shift_bit = 1'b1;
					if (sts.bit_last) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.next_bit = 1'b1;
					end
				end else if (sts.parity_odd) begin
					cmd.start_match = 1'b1;
					state_d         = ST_MATCH;
				end else begin
					// parity bit failed: drop the whole group
					cmd.drop_group = 1'b1;
					if (sts.bit_last) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.next_bit = 1'b1;
					end
				end
			end
			ST_MATCH: begin
				if (sts.full) begin
					cmd.drop_group = 1'b1;
					if (sts.bit_last) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.next_bit = 1'b1;
						state_d      = ST_BIT;
					end
				end else begin
					cmd.match_step = 1'b1;
					if (sts.lookup_ok) begin
						state_d = ST_CHECK;
					end else if (sts.k_last) begin
						// saturated pending code, no lookup
						cmd.drop_group = 1'b1;
						if (sts.bit_last) begin
							state_d = ST_FLUSH;
						end else begin
							cmd.next_bit = 1'b1;
							state_d      = ST_BIT;
						end
					end else begin
						cmd.next_k = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				// a hit must wait while both the hold and output registers are taken
				if (!(sts.hit && sts.hold_v && !sts.can_push)) begin
					cmd.take_hit = sts.hit;
					if (sts.k_last) begin
						cmd.drop_group = 1'b1;
						if (sts.bit_last) begin
							state_d = ST_FLUSH;
						end else begin
							cmd.next_bit = 1'b1;
							state_d      = ST_BIT;
						end
					end else begin
						cmd.next_k = 1'b1;
						state_d    = ST_MATCH;
					end
				end
			end
			ST_FLUSH: begin
				if (!sts.hold_v) begin
					state_d = ST_IDLE;
				end else if (sts.can_push) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

[rtl/core/pcd_datapath.sv]
// ----------------------------------------------------------------------------
// pcd_datapath
// Code table memory, group collector, pending code register, symbol count,
// one-word hold register and output register.
// ----------------------------------------------------------------------------
module pcd_datapath #(
	parameter int MAX_CODE_LEN = pcd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcd_pkg::item_t       item_data,
	pcd_stream_if.source         result,
	pcd_stream_if.sink           cfg,
	input  pcd_pkg::cmd_t        cmd,
	output pcd_pkg::sts_t        sts
);

	localparam int ADDR_W = MAX_CODE_LEN + 1;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int PC_W   = MAX_CODE_LEN;
	localparam int LEN_W  = $clog2(MAX_CODE_LEN + 2);
	localparam int SYM_W  = pcd_pkg::SYM_W;
	localparam int BIX_W  = $clog2(pcd_pkg::NIBBLE_BITS);
	localparam int K_W    = $clog2(pcd_pkg::DATA_BITS);
	localparam int FILL_W = $clog2(pcd_pkg::DATA_BITS + 1);

	// table: valid flag on top of the symbol
	logic [SYM_W:0] mem [DEPTH];
	logic [SYM_W:0] rdata_q;

	logic [ADDR_W-1:0]               clr_addr_q;
	logic [pcd_pkg::MLEN_W-1:0]      mlen_q;
	logic [pcd_pkg::MLEN_W-1:0]      count_q;
	logic [pcd_pkg::NIBBLE_BITS-1:0] nib_q;
	logic [BIX_W-1:0]                bit_idx_q;
	logic [pcd_pkg::DATA_BITS-1:0]   group_q;
	logic [FILL_W-1:0]               fill_q;
	logic [K_W-1:0]                  k_q;
	logic [PC_W-1:0]                 pend_code_q;
	logic [LEN_W-1:0]                pend_len_q;
	logic                            hold_v_q;
	logic [SYM_W-1:0]                hold_sym_q;
	logic                            hold_full_q;
	logic                            out_v_q;
	pcd_pkg::result_t                out_q;

	logic                            cur_bit;
	logic                            mb;
	logic [LEN_W-1:0]                nl;
	logic [PC_W-1:0]                 nc;
	logic [ADDR_W-1:0]               raddr;
	logic                            ld_ok;
	logic [ADDR_W-1:0]               ld_one;
	logic [ADDR_W-1:0]               ld_idx;
	logic                            we;
	logic [ADDR_W-1:0]               waddr;
	logic [SYM_W:0]                  wdata;
	logic [pcd_pkg::MLEN_W-1:0]      count_inc;
	logic                            can_push;

	assign cur_bit   = nib_q[bit_idx_q];
	assign mb        = group_q[k_q];
	assign nl        = pend_len_q + LEN_W'(1);
	assign nc        = PC_W'({pend_code_q, mb}) & PC_W'((ADDR_W'(1) << nl) - ADDR_W'(1));
	assign raddr     = (ADDR_W'(1) << nl) | ADDR_W'(nc);
	assign count_inc = count_q + pcd_pkg::MLEN_W'(1);
	assign can_push  = !out_v_q || result.ready;

	// load address: (1 << length) | masked bits
	assign ld_ok  = (item_data.code_length != 4'd0) &&
	                (32'(item_data.code_length) <= MAX_CODE_LEN);
	assign ld_one = ADDR_W'(1) << item_data.code_length;
	assign ld_idx = ld_one | (ADDR_W'(item_data.code_bits) & (ld_one - ADDR_W'(1)));

	assign we    = cmd.clr_step || (cmd.load && ld_ok);
	assign waddr = cmd.clr_step ? clr_addr_q : ld_idx;
	assign wdata = cmd.clr_step ? '0 : {1'b1, item_data.entry_symbol};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match_step) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			mlen_q      <= '0;
			count_q     <= '0;
			group_q     <= '0;
			fill_q      <= '0;
			pend_code_q <= '0;
			pend_len_q  <= '0;
			hold_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			bit_idx_q   <= '0;
			k_q         <= '0;
		end else begin
			if (cfg.valid) begin
				mlen_q <= cfg.data;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.take_nib) begin
				bit_idx_q <= BIX_W'(pcd_pkg::NIBBLE_BITS - 1);
			end
			if (cmd.next_bit) begin
				bit_idx_q <= bit_idx_q - BIX_W'(1);
			end
			if (cmd.start_match) begin
				k_q <= K_W'(pcd_pkg::DATA_BITS - 1);
			end
			if (cmd.next_k) begin
				k_q <= k_q - K_W'(1);
			end
			if (cmd.shift_bit) begin
				group_q <= {group_q[pcd_pkg::DATA_BITS-2:0], cur_bit};
				fill_q  <= fill_q + FILL_W'(1);
			end
			if (cmd.drop_group || cmd.clr_start) begin
				group_q <= '0;
				fill_q  <= '0;
			end
			if (cmd.match_step && (pend_len_q <= LEN_W'(MAX_CODE_LEN))) begin
				// saturates one above the longest code
				pend_len_q <= nl;
				if (pend_len_q < LEN_W'(MAX_CODE_LEN)) begin
					pend_code_q <= nc;
				end
			end
			if (cmd.take_hit || cmd.clr_start) begin
				pend_code_q <= '0;
				pend_len_q  <= '0;
			end
			if (cmd.take_hit) begin
				count_q  <= count_inc;
				hold_v_q <= 1'b1;
			end
			if (cmd.clr_start) begin
				count_q <= '0;
			end
			if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
			if ((cmd.take_hit && hold_v_q) || cmd.flush) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_nib) begin
			nib_q <= item_data.nibble;
		end
		if (cmd.take_hit) begin
			hold_sym_q  <= rdata_q[SYM_W-1:0];
			hold_full_q <= (count_inc == mlen_q);
		end
		if ((cmd.take_hit && hold_v_q) || cmd.flush) begin
			out_q.symbol       <= hold_sym_q;
			out_q.last         <= cmd.flush;
			out_q.message_full <= hold_full_q;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;
	assign cfg.ready    = 1'b1;

	assign sts.full       = (count_q >= mlen_q);
	assign sts.grp_full   = (fill_q == FILL_W'(pcd_pkg::DATA_BITS));
	assign sts.parity_odd = ^{group_q, cur_bit};
	assign sts.bit_last   = (bit_idx_q == '0);
	assign sts.k_last     = (k_q == '0);
	assign sts.lookup_ok  = (pend_len_q < LEN_W'(MAX_CODE_LEN));
	assign sts.hit        = rdata_q[SYM_W];
	assign sts.hold_v     = hold_v_q;
	assign sts.can_push   = can_push;
	assign sts.clr_done   = (clr_addr_q == '1);

endmodule

[rtl/core/pcd_checker.sv]
// ----------------------------------------------------------------------------
// pcd_checker
// Port level checks of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic [1:0] item_op,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] result_symbol,
	input logic       result_last,
	input logic       result_full
);

	// stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_symbol) &&
		$stable(result_last) && $stable(result_full))
		else $error("result word changed while stalled");

	// nibble and clear ops keep the block busy once accepted, with item_ready low
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready &&
		(item_op == pcd_pkg::OP_DATA || item_op == pcd_pkg::OP_CLEAR) |=> !item_ready)
		else $error("item accepted straight after a multi-cycle op");

	// only nibble words cause results
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_op != pcd_pkg::OP_DATA |=> !$rose(result_valid))
		else $error("result raised by a non-data word");

	// a symbol that is not the last of its nibble means that nibble is still in work
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_last |-> !item_ready)
		else $error("item taken before the last symbol was queued");

endmodule

bind parity_checked_prefix_code_decoder pcd_checker u_pcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_op       (item.data.op),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_symbol (result.data.symbol),
	.result_last   (result.data.last),
	.result_full   (result.data.message_full)
);

[sim/tb_parity_checked_prefix_code_decoder.sv]
// ----------------------------------------------------------------------------
// tb_parity_checked_prefix_code_decoder
// Self-checking bench for the parity checked prefix code decoder. Hex nibbles
// are built from 9-bit groups, mostly prefix code words with good parity, and
// every decoded symbol is compared against a behavioural copy of the decoder.
// ----------------------------------------------------------------------------
module tb_parity_checked_prefix_code_decoder;
	import pcd_pkg::*;

	localparam int         CLK_PERIOD     = 10;
	localparam int         MAX_LEN        = MAX_CODE_LEN_DEF;
	localparam int         TAB_DEPTH      = 2 << MAX_LEN;
	localparam int         SWEEP_CYCLES   = TAB_DEPTH + 16;
	localparam int         SETTLE_CYCLES  = 32;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         TIMEOUT_CYCLES = 3000000;
	localparam logic [1:0] OP_SPARE       = 2'd3;

	logic clk;
	logic arst_n;

	pcd_stream_if #(.payload_t(item_t))   item_ch ();
	pcd_stream_if #(.payload_t(result_t)) result_ch ();
	pcd_stream_if #(.payload_t(cfg_t))    cfg_ch ();

	parity_checked_prefix_code_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// decoder state as the bench sees it
	logic [8:0]  code_tab [TAB_DEPTH];
	logic [7:0]  grp_data;
	logic [3:0]  grp_fill;
	logic [9:0]  pend_code;
	logic [3:0]  pend_len;
	logic [15:0] sym_count;
	cfg_t        msg_len;
	result_t     symbols_due [$];

	// stimulus state
	int   tx_idle_pct = 22;
	int   rx_idle_pct = 56;
	bit   hold_request = 1'b0;
	int   hold_left = 0;
	bit   sweep_due = 1'b1;
	logic stream_bits [$];
	logic code_stream [$];
	logic [9:0] cw_bits [$];
	int   cw_len [$];

	int errors = 0;
	int items_sent = 0;
	int symbols_checked = 0;
	int fulls_seen = 0;
	int groups_dropped = 0;
	int messages_started = 0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic void clear_decoder();
		foreach (code_tab[i]) code_tab[i] = '0;
		grp_data  = '0;
		grp_fill  = '0;
		pend_code = '0;
		pend_len  = '0;
		sym_count = '0;
	endfunction

	// one data bit into the matcher, returns 1 on a table hit
	function automatic bit match_bit(input logic b, output logic [7:0] sym);
		int unsigned grown;
		int unsigned idx;
		sym = '0;
		if (pend_len > MAX_LEN)
			return 1'b0;
		pend_len++;
		if (pend_len > MAX_LEN)
			return 1'b0;
		grown = ((int'(pend_code) << 1) | b) & ((1 << pend_len) - 1);
		pend_code = 10'(grown);
		idx = (1 << pend_len) | grown;
		if (!code_tab[idx][8])
			return 1'b0;
		sym = code_tab[idx][7:0];
		pend_code = '0;
		pend_len = '0;
		return 1'b1;
	endfunction

	function automatic void decode_item(input item_t it);
		result_t     outs [8];
		int          n;
		int          i;
		int          k;
		int unsigned mask;
		logic        b;
		logic [7:0]  sym;
		n = 0;
		case (it.op)
			OP_LOAD: begin
				if (it.code_length >= 1 && it.code_length <= MAX_LEN) begin
					mask = (1 << it.code_length) - 1;
					code_tab[(1 << it.code_length) | (it.code_bits & mask)] =
						{1'b1, it.entry_symbol};
				end
			end
			OP_CLEAR: clear_decoder();
			OP_DATA: begin
				for (i = NIBBLE_BITS - 1; i >= 0; i--) begin
					b = it.nibble[i];
					if (sym_count >= msg_len)
						break;
					if (grp_fill < DATA_BITS) begin
						grp_data = {grp_data[6:0], b};
						grp_fill++;
					end else begin
						// ninth bit: keep the group only on odd parity overall
						if ((^grp_data) ^ b) begin
							for (k = DATA_BITS - 1; k >= 0; k--) begin
								if (sym_count >= msg_len)
									break;
								if (match_bit(grp_data[k], sym)) begin
									sym_count++;
									outs[n] = '{symbol: sym, last: 1'b0,
										message_full: (sym_count == msg_len)};
									n++;
								end
							end
						end else begin
							groups_dropped++;
						end
						grp_data = '0;
						grp_fill = '0;
					end
				end
				if (n > 0)
					outs[n - 1].last = 1'b1;
				for (k = 0; k < n; k++)
					symbols_due = {symbols_due, outs[k]};
			end
			default: ;
		endcase
	endfunction

	function automatic item_t rand_item(input logic [1:0] op);
		item_t it;
		it.op           = op;
		it.nibble       = 4'($urandom);
		it.code_bits    = 10'($urandom);
		it.code_length  = 4'($urandom);
		it.entry_symbol = 8'($urandom);
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		decode_item(it);
		sweep_due = (it.op == OP_CLEAR);
		if (it.op != OP_SPARE)
			items_sent++;
	endtask

	task automatic send_load(input logic [9:0] bits, input logic [3:0] len,
			input logic [7:0] sym);
		item_t it;
		it = rand_item(OP_LOAD);
		it.code_bits    = bits;
		it.code_length  = len;
		it.entry_symbol = sym;
		send_item(it);
	endtask

	// partial bits still queued belong to a group the clear throws away
	task automatic send_clear();
		item_t it;
		stream_bits.delete();
		it = rand_item(OP_CLEAR);
		send_item(it);
		messages_started++;
	endtask

	// queue one group of eight data bits and a parity bit, send whole nibbles
	task automatic push_group(input logic [7:0] data, input bit parity_ok);
		item_t it;
		int    j;
		for (j = DATA_BITS - 1; j >= 0; j--)
			stream_bits = {stream_bits, data[j]};
		stream_bits = {stream_bits, parity_ok ? ~(^data) : (^data)};
		while (stream_bits.size() >= NIBBLE_BITS) begin
			it = rand_item(OP_DATA);
			for (j = NIBBLE_BITS - 1; j >= 0; j--)
				it.nibble[j] = stream_bits.pop_front();
			send_item(it);
		end
	endtask

	task automatic wait_for_idle();
		item_ch.valid <= 1'b0;
		while (symbols_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		// table sweep after a clear still running
		if (sweep_due) begin
			repeat (SWEEP_CYCLES) @(posedge clk);
			sweep_due = 1'b0;
		end
	endtask

	task automatic write_message_length(input cfg_t v);
		wait_for_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		msg_len = v;
	endtask

	// canonical prefix code with non-decreasing lengths, junk above each length
	task automatic load_code_set();
		int          n;
		int          len;
		int          prev;
		int unsigned code;
		logic [9:0]  low_mask;
		item_t       it;
		cw_bits.delete();
		cw_len.delete();
		code_stream.delete();
		n = $urandom_range(2, 12);
		len = $urandom_range(1, 3);
		code = 0;
		while (cw_len.size() < n && code < (1 << len)) begin
			cw_bits = {cw_bits, 10'(code)};
			cw_len = {cw_len, len};
			low_mask = 10'((1 << len) - 1);
			it = rand_item(OP_LOAD);
			it.code_length = 4'(len);
			it.code_bits = (it.code_bits & ~low_mask) | 10'(code);
			send_item(it);
			code++;
			prev = len;
			len = prev + $urandom_range(0, 2);
			if (len > MAX_LEN)
				len = MAX_LEN;
			code = code << (len - prev);
		end
	endtask

	function automatic logic [7:0] next_code_byte();
		logic [7:0] v;
		int         j;
		int         pick;
		while (code_stream.size() < DATA_BITS) begin
			pick = $urandom_range(0, cw_len.size() - 1);
			for (j = cw_len[pick] - 1; j >= 0; j--)
				code_stream = {code_stream, cw_bits[pick][j]};
		end
		for (j = DATA_BITS - 1; j >= 0; j--)
			v[j] = code_stream.pop_front();
		return v;
	endfunction

	task automatic start_message();
		send_clear();
		load_code_set();
	endtask

	task automatic test_table_loads();
		item_t it;
		write_message_length(16'hFFFF);
		send_load(10'h3FE, 4'd1, 8'hA5);	// masked down to the one-bit code 0
		send_load(10'h3FF, 4'd10, 8'hFF);
		send_load(10'h001, 4'd0, 8'h11);	// zero length, ignored
		send_load(10'h2AA, 4'd15, 8'h22);
		send_load(10'h155, 4'd11, 8'h33);	// longer than the table allows
		send_load(10'h000, 4'd1, 8'h5A);	// reload overwrites
		it = rand_item(OP_SPARE);
		send_item(it);
		push_group(8'h00, 1'b1);
	endtask

	task automatic test_parity_filter();
		push_group(8'h00, 1'b0);
		// sixteen ones: the ten-bit code hits, six stay pending
		push_group(8'hFF, 1'b1);
		push_group(8'hFF, 1'b1);
	endtask

	task automatic test_overlong_code();
		push_group(8'hAA, 1'b1);
		push_group(8'h00, 1'b1);
		push_group(8'h00, 1'b1);
		push_group(8'h00, 1'b1);
	endtask

	task automatic test_message_full();
		write_message_length(16'd3);
		send_clear();
		send_load(10'h000, 4'd1, 8'hC3);
		push_group(8'h00, 1'b1);
		push_group(8'h00, 1'b1);
		write_message_length(16'd0);
		send_clear();
		send_load(10'h000, 4'd1, 8'h81);
		push_group(8'h00, 1'b1);
	endtask

	// receiver holds off while short codes pile up symbols
	task automatic test_output_stall();
		write_message_length(16'hFFFF);
		send_clear();
		send_load(10'h000, 4'd1, 8'h3C);
		hold_request = 1'b1;
		repeat (6) push_group(8'h00, 1'b1);
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input cfg_t len,
			input int n_items);
		int    first;
		int    roll;
		item_t it;
		write_message_length(len);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start_message();
		first = items_sent;
		while (items_sent - first < n_items) begin
			if (sym_count >= msg_len || pend_len > MAX_LEN) begin
				start_message();
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 72) begin
					push_group(next_code_byte(), $urandom_range(0, 19) != 0);
				end else if (roll < 82) begin
					push_group(8'($urandom), 1'($urandom));
				end else if (roll < 94) begin
					it = rand_item(OP_LOAD);
					send_item(it);
				end else begin
					it = rand_item(OP_SPARE);
					send_item(it);
				end
			end
		end
	endtask

	initial begin : receiver
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin : symbol_checker
		result_t want;
		result_t got;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got = result_ch.data;
				if (symbols_due.size() == 0) begin
					$error("result word %0h with no symbol expected", got);
					errors++;
				end else begin
					want = symbols_due.pop_front();
					symbols_checked++;
					if (want.message_full)
						fulls_seen++;
					if (got.symbol !== want.symbol) begin
						$error("symbol: expected %0h, got %0h", want.symbol, got.symbol);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, got.last);
						errors++;
					end
					if (got.message_full !== want.message_full) begin
						$error("message_full: expected %0b, got %0b",
							want.message_full, got.message_full);
						errors++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("** parity_checked_prefix_code_decoder: FAILED **");
		$finish;
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		clear_decoder();
		msg_len = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_loads();
		test_parity_filter();
		test_overlong_code();
		test_message_full();
		test_output_stall();
		test_random_traffic(22, 56, 16'hFFFF, 110);
		test_random_traffic(56, 22, cfg_t'($urandom_range(12, 40)), 110);
		test_random_traffic(0, 0, cfg_t'($urandom_range(60, 400)), 100);

		wait_for_idle();
		$display("covered %0d words in, %0d symbols checked, %0d of them ending a message",
			items_sent, symbols_checked, fulls_seen);
		$display("%0d messages started, %0d groups dropped on even parity",
			messages_started, groups_dropped);
		if (errors == 0) begin
			$display("** parity_checked_prefix_code_decoder: PASSED **");
		end else begin
			$display("** parity_checked_prefix_code_decoder: FAILED **");
		end
		$finish;
	end

endmodule

[parity_checked_prefix_code_decoder.f]
rtl/core/pcd_pkg.sv
rtl/core/pcd_stream_if.sv
rtl/core/pcd_ctrl.sv
rtl/core/pcd_datapath.sv
rtl/core/parity_checked_prefix_code_decoder.sv
rtl/core/pcd_checker.sv
sim/tb_parity_checked_prefix_code_decoder.sv
